[sv/irradiance_cache_interpolator_defines.svh]
// assertion macros for the irradiance cache interpolator checker
// expects clk_i and rst_ni in the scope of use
`ifndef IRRADIANCE_CACHE_INTERPOLATOR_DEFINES_SVH
`define IRRADIANCE_CACHE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define ICI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ICI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ici_pkg.sv]
// shared constants for the irradiance cache interpolator
// no dependencies
`default_nettype none

package ici_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] CFG_MIN_COS    = 2'd0;
  localparam logic [1:0] CFG_PLANAR     = 2'd1;
  localparam logic [1:0] CFG_SMOOTH     = 2'd2;
  localparam logic [1:0] CFG_MIN_ACCEPT = 2'd3;

  localparam logic [15:0] RST_MIN_COS    = 16'd15565;
  localparam logic [14:0] RST_PLANAR     = 15'd819;
  localparam logic [15:0] RST_SMOOTH     = 16'd256;
  localparam logic [7:0]  RST_MIN_ACCEPT = 8'd1;

  localparam logic [23:0] CNT_MAX  = 24'hFFFFFF;
  localparam logic [39:0] WSUM_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [30:0] CH_MAX   = 31'h7FFF_FFFF;

endpackage

`default_nettype wire

[sv/ici_if.sv]
// request channels of the irradiance cache interpolator
// item, configuration write and result; no dependencies
`default_nettype none

interface ici_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [31:0] vec_a_x;
  logic [31:0] vec_a_y;
  logic [31:0] vec_a_z;
  logic [15:0] vec_b_x;
  logic [15:0] vec_b_y;
  logic [15:0] vec_b_z;
  logic [30:0] sample_radius;
  logic [30:0] irr_red;
  logic [30:0] irr_green;
  logic [30:0] irr_blue;

  modport source (output valid, opcode, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y,
                  vec_b_z, sample_radius, irr_red, irr_green, irr_blue, input ready);
  modport sink (input valid, opcode, vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y,
                vec_b_z, sample_radius, irr_red, irr_green, irr_blue, output ready);
endinterface

interface ici_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface ici_out_if;
  logic        valid;
  logic        ready;
  logic        success;
  logic [30:0] out_red;
  logic [30:0] out_green;
  logic [30:0] out_blue;
  logic [23:0] checked_count;
  logic [23:0] accepted_count;

  modport source (output valid, success, out_red, out_green, out_blue, checked_count,
                  accepted_count, input ready);
  modport sink (input valid, success, out_red, out_green, out_blue, checked_count,
                accepted_count, output ready);
endinterface

`default_nettype wire

[sv/irradiance_cache_interpolator.sv]
// irradiance cache interpolator: fixed point weighted blend of cached samples
// depends on ici_pkg and the channel interfaces in ici_if.sv
//
//   channel  dir  carries
//   in_i     in   opcode, sample point/normal, radius, irradiance
//   cfg_i    in   register index and write data, always ready
//   out_o    out  success, mean irradiance, checked and accepted counts
//
// begin is taken in the idle state; a sample, ended sooner when rejected early, runs
// the bit-serial multiplier (one multiplier bit a cycle, 17 products),
// the 32-step square root and the 64-step divider
// finish runs three 64-step divisions, then holds in the output state while a result still waits
// reset clears all state; no clearing pass
// a result waits in the output register; begin and sample requests go on meanwhile
`default_nettype none

module irradiance_cache_interpolator import ici_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  ici_in_if.sink    in_i,
  ici_cfg_if.sink   cfg_i,
  ici_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_SQRT, S_DIV, S_COS, S_D2, S_R2, S_PD,
    S_LIM, S_RC, S_DEN, S_W, S_W2, S_ACC, S_FIN, S_OUT
  } state_e;

  state_e state_q, ret_q;
  logic [1:0] idx_q, idx_n;

  logic signed [15:0] mnc_q;
  logic [14:0] mpr_q;
  logic [15:0] smooth_q;
  logic [7:0]  minacc_q;

  logic signed [31:0] qpos_q [3];
  logic signed [15:0] qnrm_q [3];
  logic [63:0] wirr_q [3];
  logic [39:0] wsum_q;
  logic [23:0] chk_q, acc_q;

  logic signed [32:0] d_q [3];
  logic signed [15:0] sn_q [3];
  logic [30:0] rad_q;
  logic [30:0] irr_q [3];

  logic signed [33:0] cos_q;
  logic [63:0] d2_q;
  logic signed [49:0] pdot_q;
  logic [30:0] dist_q;
  logic [16:0] w_q;
  logic [30:0] mean_q [3];
  logic ok_q;

  // shared serial units
  logic [63:0] ma_q, prod_q, x_q, r_q, bit_q;
  logic signed [33:0] mb_q;
  logic [6:0] cnt_q;

  logic out_valid_q, success_q;
  logic [30:0] red_q, green_q, blue_q;
  logic [23:0] ochk_q, oacc_q;

  logic [63:0] mul_add, sq_t, sq_r, rem_sh;
  logic sq_ge, dv_ge;
  logic signed [33:0] cos_n, mnc_ext;
  logic [63:0] d2_n;
  logic signed [49:0] pdot_n;
  logic [49:0] apd;
  logic [43:0] den;
  logic [16:0] om, wv;
  logic [40:0] wsum_s;
  logic [64:0] wirr_s;
  logic d_far, fin_ok;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  assign idx_n = idx_q + 2'd1;

  always_comb begin
    // last multiplier bit carries negative weight
    mul_add = mb_q[0] ? ((cnt_q == 7'd1) ? -ma_q : ma_q) : '0;
    sq_t    = r_q + bit_q;
    sq_ge   = x_q >= sq_t;
    sq_r    = sq_ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
    rem_sh  = {r_q[62:0], x_q[63]};
    dv_ge   = rem_sh >= bit_q;
    cos_n   = cos_q + prod_q[33:0];
    mnc_ext = {{4{mnc_q[15]}}, mnc_q, 14'b0};
    d2_n    = d2_q + prod_q;
    pdot_n  = pdot_q + prod_q[49:0];
    apd     = pdot_q[49] ? 50'(-pdot_q) : 50'(pdot_q);
    den     = prod_q[51:8];
    om      = 17'h10000 - x_q[16:0];
    wv      = prod_q[32:16];
    wsum_s  = {1'b0, wsum_q} + {24'b0, wv};
    wirr_s  = {1'b0, wirr_q[idx_q]} + {1'b0, prod_q};
    d_far   = (abs33(d_q[0]) > {2'b0, rad_q}) || (abs33(d_q[1]) > {2'b0, rad_q})
           || (abs33(d_q[2]) > {2'b0, rad_q});
    fin_ok  = (acc_q >= {16'b0, minacc_q}) && (wsum_q != '0);
  end

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.success        = success_q;
  assign out_o.out_red        = red_q;
  assign out_o.out_green      = green_q;
  assign out_o.out_blue       = blue_q;
  assign out_o.checked_count  = ochk_q;
  assign out_o.accepted_count = oacc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      idx_q <= '0;
      mnc_q <= RST_MIN_COS;
      mpr_q <= RST_PLANAR;
      smooth_q <= RST_SMOOTH;
      minacc_q <= RST_MIN_ACCEPT;
      for (int i = 0; i < 3; i++) begin
        qpos_q[i] <= '0;
        qnrm_q[i] <= '0;
        wirr_q[i] <= '0;
        d_q[i] <= '0;
        sn_q[i] <= '0;
        irr_q[i] <= '0;
        mean_q[i] <= '0;
      end
      wsum_q <= '0;
      chk_q <= '0;
      acc_q <= '0;
      rad_q <= '0;
      cos_q <= '0;
      d2_q <= '0;
      pdot_q <= '0;
      dist_q <= '0;
      w_q <= '0;
      ok_q <= 1'b0;
      ma_q <= '0;
      mb_q <= '0;
      prod_q <= '0;
      x_q <= '0;
      r_q <= '0;
      bit_q <= '0;
      cnt_q <= '0;
      out_valid_q <= 1'b0;
      success_q <= 1'b0;
      red_q <= '0;
      green_q <= '0;
      blue_q <= '0;
      ochk_q <= '0;
      oacc_q <= '0;
    end else begin
      if (cfg_i.valid) begin
        unique case (cfg_i.index)
          CFG_MIN_COS:    mnc_q <= cfg_i.data;
          CFG_PLANAR:     mpr_q <= cfg_i.data[14:0];
          CFG_SMOOTH:     smooth_q <= cfg_i.data;
          CFG_MIN_ACCEPT: minacc_q <= cfg_i.data[7:0];
        endcase
      end

      // the output state reloads the register itself
      if (out_valid_q && out_o.ready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            unique case (in_i.opcode)
              OP_BEGIN: begin
                qpos_q[0] <= in_i.vec_a_x;
                qpos_q[1] <= in_i.vec_a_y;
                qpos_q[2] <= in_i.vec_a_z;
                qnrm_q[0] <= in_i.vec_b_x;
                qnrm_q[1] <= in_i.vec_b_y;
                qnrm_q[2] <= in_i.vec_b_z;
                for (int i = 0; i < 3; i++) wirr_q[i] <= '0;
                wsum_q <= '0;
                chk_q <= '0;
                acc_q <= '0;
              end
              OP_SAMPLE: begin
                if (chk_q != CNT_MAX) chk_q <= chk_q + 24'd1;
                d_q[0] <= {in_i.vec_a_x[31], in_i.vec_a_x} - {qpos_q[0][31], qpos_q[0]};
                d_q[1] <= {in_i.vec_a_y[31], in_i.vec_a_y} - {qpos_q[1][31], qpos_q[1]};
                d_q[2] <= {in_i.vec_a_z[31], in_i.vec_a_z} - {qpos_q[2][31], qpos_q[2]};
                sn_q[0] <= in_i.vec_b_x;
                sn_q[1] <= in_i.vec_b_y;
                sn_q[2] <= in_i.vec_b_z;
                rad_q <= in_i.sample_radius;
                irr_q[0] <= in_i.irr_red;
                irr_q[1] <= in_i.irr_green;
                irr_q[2] <= in_i.irr_blue;
                cos_q <= '0;
                idx_q <= '0;
                ma_q <= {{48{qnrm_q[0][15]}}, qnrm_q[0]};
                mb_q <= {{18{in_i.vec_b_x[15]}}, in_i.vec_b_x};
                cnt_q <= 7'd16;
                prod_q <= '0;
                ret_q <= S_COS;
                state_q <= S_MUL;
              end
              OP_FINISH: begin
                ok_q <= fin_ok;
                idx_q <= '0;
                if (fin_ok) begin
                  x_q <= wirr_q[0];
                  r_q <= '0;
                  bit_q <= {24'b0, wsum_q};
                  cnt_q <= 7'd64;
                  ret_q <= S_FIN;
                  state_q <= S_DIV;
                end else begin
                  for (int i = 0; i < 3; i++) mean_q[i] <= '0;
                  state_q <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end

        S_MUL: begin
          prod_q <= prod_q + mul_add;
          ma_q <= ma_q << 1;
          mb_q <= mb_q >>> 1;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) state_q <= ret_q;
        end

        S_SQRT: begin
          x_q <= sq_ge ? (x_q - sq_t) : x_q;
          r_q <= sq_r;
          bit_q <= bit_q >> 2;
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) begin
            dist_q <= sq_r[30:0];
            pdot_q <= '0;
            idx_q <= '0;
            ma_q <= {{31{d_q[0][32]}}, d_q[0]};
            mb_q <= {{18{qnrm_q[0][15]}}, qnrm_q[0]};
            cnt_q <= 7'd16;
            prod_q <= '0;
            ret_q <= S_PD;
            state_q <= S_MUL;
          end
        end

        S_DIV: begin
          r_q <= dv_ge ? (rem_sh - bit_q) : rem_sh;
          x_q <= {x_q[62:0], dv_ge};
          cnt_q <= cnt_q - 7'd1;
          if (cnt_q == 7'd1) state_q <= ret_q;
        end

        S_COS: begin
          cos_q <= cos_n;
          if (idx_q != 2'd2) begin
            idx_q <= idx_n;
            ma_q <= {{48{qnrm_q[idx_n][15]}}, qnrm_q[idx_n]};
            mb_q <= {{18{sn_q[idx_n][15]}}, sn_q[idx_n]};
            cnt_q <= 7'd16;
            prod_q <= '0;
            state_q <= S_MUL;
          end else if ((cos_n < mnc_ext) || d_far) begin
            state_q <= S_IDLE;
          end else begin
            d2_q <= '0;
            idx_q <= '0;
            ma_q <= {{31{d_q[0][32]}}, d_q[0]};
            mb_q <= {d_q[0][32], d_q[0]};
            cnt_q <= 7'd33;
            prod_q <= '0;
            ret_q <= S_D2;
            state_q <= S_MUL;
          end
        end

        S_D2: begin
          d2_q <= d2_n;
          prod_q <= '0;
          state_q <= S_MUL;
          if (idx_q != 2'd2) begin
            idx_q <= idx_n;
            ma_q <= {{31{d_q[idx_n][32]}}, d_q[idx_n]};
            mb_q <= {d_q[idx_n][32], d_q[idx_n]};
            cnt_q <= 7'd33;
          end else begin
            ma_q <= {33'b0, rad_q};
            mb_q <= {3'b0, rad_q};
            cnt_q <= 7'd32;
            ret_q <= S_R2;
          end
        end

        S_R2: begin
          if (d2_q > prod_q) begin
            state_q <= S_IDLE;
          end else begin
            x_q <= d2_q;
            r_q <= '0;
            bit_q <= 64'h4000_0000_0000_0000;
            cnt_q <= 7'd32;
            state_q <= S_SQRT;
          end
        end

        S_PD: begin
          pdot_q <= pdot_n;
          prod_q <= '0;
          state_q <= S_MUL;
          if (idx_q != 2'd2) begin
            idx_q <= idx_n;
            ma_q <= {{31{d_q[idx_n][32]}}, d_q[idx_n]};
            mb_q <= {{18{qnrm_q[idx_n][15]}}, qnrm_q[idx_n]};
            cnt_q <= 7'd16;
          end else begin
            ma_q <= {33'b0, dist_q};
            mb_q <= {19'b0, mpr_q};
            cnt_q <= 7'd16;
            ret_q <= S_LIM;
          end
        end

        S_LIM: begin
          // planar test, then a cosine that is not positive gives no radius
          if ((apd > prod_q[49:0]) || cos_q[33] || (cos_q == '0)) begin
            state_q <= S_IDLE;
          end else begin
            ma_q <= {33'b0, rad_q};
            mb_q <= {15'b0, cos_q[32:14]};
            cnt_q <= 7'd20;
            prod_q <= '0;
            ret_q <= S_RC;
            state_q <= S_MUL;
          end
        end

        S_RC: begin
          ma_q <= {28'b0, prod_q[49:14]};
          mb_q <= {18'b0, smooth_q};
          cnt_q <= 7'd17;
          prod_q <= '0;
          ret_q <= S_DEN;
          state_q <= S_MUL;
        end

        S_DEN: begin
          if ((den == '0) || ({13'b0, dist_q} >= den)) begin
            state_q <= S_IDLE;
          end else begin
            x_q <= {17'b0, dist_q, 16'b0};
            r_q <= '0;
            bit_q <= {20'b0, den};
            cnt_q <= 7'd64;
            ret_q <= S_W;
            state_q <= S_DIV;
          end
        end

        S_W: begin
          ma_q <= {47'b0, om};
          mb_q <= {17'b0, om};
          cnt_q <= 7'd18;
          prod_q <= '0;
          ret_q <= S_W2;
          state_q <= S_MUL;
        end

        S_W2: begin
          w_q <= wv;
          if (acc_q != CNT_MAX) acc_q <= acc_q + 24'd1;
          wsum_q <= wsum_s[40] ? WSUM_MAX : wsum_s[39:0];
          idx_q <= '0;
          ma_q <= {33'b0, irr_q[0]};
          mb_q <= {17'b0, wv};
          cnt_q <= 7'd18;
          prod_q <= '0;
          ret_q <= S_ACC;
          state_q <= S_MUL;
        end

        S_ACC: begin
          wirr_q[idx_q] <= wirr_s[64] ? '1 : wirr_s[63:0];
          if (idx_q != 2'd2) begin
            idx_q <= idx_n;
            ma_q <= {33'b0, irr_q[idx_n]};
            mb_q <= {17'b0, w_q};
            cnt_q <= 7'd18;
            prod_q <= '0;
            state_q <= S_MUL;
          end else begin
            state_q <= S_IDLE;
          end
        end

        S_FIN: begin
          mean_q[idx_q] <= (x_q > {33'b0, CH_MAX}) ? CH_MAX : x_q[30:0];
          if (idx_q != 2'd2) begin
            idx_q <= idx_n;
            x_q <= wirr_q[idx_n];
            r_q <= '0;
            cnt_q <= 7'd64;
            state_q <= S_DIV;
          end else begin
            state_q <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q <= 1'b1;
            success_q <= ok_q;
            red_q <= mean_q[0];
            green_q <= mean_q[1];
            blue_q <= mean_q[2];
            ochk_q <= chk_q;
            oacc_q <= acc_q;
            state_q <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/ici_checker.sv]
// port-level checks for the irradiance cache interpolator
// depends on irradiance_cache_interpolator_defines.svh; bound to the top level below
`default_nettype none
`include "irradiance_cache_interpolator_defines.svh"

module ici_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_valid_i,
  input logic        cfg_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        success_i,
  input logic [30:0] out_red_i,
  input logic [30:0] out_green_i,
  input logic [30:0] out_blue_i,
  input logic [23:0] checked_count_i,
  input logic [23:0] accepted_count_i
);

  logic no_color;

  assign no_color = (out_red_i == '0) && (out_green_i == '0) && (out_blue_i == '0);

  `ICI_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")
  `ICI_ASSERT_IMP(a_fail_zero, out_valid_i && !success_i, no_color, "failed result has color")
  `ICI_ASSERT_IMP(a_count_order, out_valid_i, accepted_count_i <= checked_count_i, "accepted above checked")
  `ICI_ASSERT_IMP(a_success_count, out_valid_i && success_i, accepted_count_i != '0, "success with no samples")
  `ICI_ASSERT_IMP(a_cfg_ready, cfg_valid_i, cfg_ready_i, "config write stalled")

endmodule

bind irradiance_cache_interpolator ici_checker u_ici_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .cfg_valid_i      (cfg_i.valid),
  .cfg_ready_i      (cfg_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .success_i        (out_o.success),
  .out_red_i        (out_o.out_red),
  .out_green_i      (out_o.out_green),
  .out_blue_i       (out_o.out_blue),
  .checked_count_i  (out_o.checked_count),
  .accepted_count_i (out_o.accepted_count)
);

`default_nettype wire
